// ----- hw/rtl/prtm_pkg.sv -----
// Shared types and constants for the poll retry timeout manager.
`timescale 1ns / 1ps

package prtm_pkg;

	// Width of the wrapping millisecond timer.
	localparam int TIME_BITS = 32;

	// Comparison width: wide enough for the timer and for every 32-bit delay.
	localparam int CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

	// Field widths.
	localparam int NOW_BITS   = 32;
	localparam int TRY_BITS   = 8;
	localparam int STATE_BITS = 3;
	localparam int SEND_BITS  = 2;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	// Packed stream widths, rounded up to whole bytes.
	localparam int IN_BITS  = 40;
	localparam int OUT_BITS = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_SCAN_PERIOD    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RESPONSE_DELAY = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RESET_DELAY    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_TRIES      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_KIND     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_USE_INTERRUPT  = 3'd5;

	// Frame send codes.
	localparam logic [SEND_BITS-1:0] SEND_NONE    = 2'd0;
	localparam logic [SEND_BITS-1:0] SEND_REQUEST = 2'd1;
	localparam logic [SEND_BITS-1:0] SEND_ZERO    = 2'd2;

	// Reported state codes.
	localparam logic [STATE_BITS-1:0] ST_IDLE       = 3'd0;
	localparam logic [STATE_BITS-1:0] ST_WAIT_IRQ   = 3'd1;
	localparam logic [STATE_BITS-1:0] ST_WAIT_SCAN  = 3'd2;
	localparam logic [STATE_BITS-1:0] ST_WAIT_RESP  = 3'd3;
	localparam logic [STATE_BITS-1:0] ST_WAIT_RESET = 3'd4;

	// Poll state machine, one-hot.
	typedef enum logic [4:0] {
		PH_IDLE       = 5'b00001,
		PH_WAIT_IRQ   = 5'b00010,
		PH_WAIT_SCAN  = 5'b00100,
		PH_WAIT_RESP  = 5'b01000,
		PH_WAIT_RESET = 5'b10000
	} phase_t;

	// Map the one-hot phase to its reported code.
	function automatic logic [STATE_BITS-1:0] phase_code(input phase_t ph);
		logic [STATE_BITS-1:0] code;
		case (ph)
			PH_WAIT_IRQ:   code = ST_WAIT_IRQ;
			PH_WAIT_SCAN:  code = ST_WAIT_SCAN;
			PH_WAIT_RESP:  code = ST_WAIT_RESP;
			PH_WAIT_RESET: code = ST_WAIT_RESET;
			default:       code = ST_IDLE;
		endcase
		return code;
	endfunction

endpackage

// ----- hw/rtl/poll_retry_timeout_manager_unit.sv -----
// Top level of the poll retry timeout manager.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata: process step sample
// m_*       out        m_tvalid / m_tready  m_tdata: command and status
// cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data: register write
//
// Each request is captured in an input register and its result is then
// registered in the output register. One request is taken every cycle while
// the output is not stalled; the state update (one 16x9 multiply and a compare) sits
// between those two registers. When the result is not taken, the input
// register holds one more request and then s_tready drops. Reset clears the
// poll state and valid flags and sets the configuration registers to their defaults.
module poll_retry_timeout_manager_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// Fields from bit 0: now_ms[31:0], enabled, zero_request, device_ready,
	// irq_pending, response_ready, zero fill.
	input  logic [prtm_pkg::IN_BITS-1:0]          s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// Fields from bit 0: send_frame[1:0], take_response, flush_device,
	// clear_irq, state_now[2:0], tries_done[7:0].
	output logic [prtm_pkg::OUT_BITS-1:0]         m_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [prtm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [prtm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	// Configuration registers. The frame kind is accepted but does not
	// affect any result, so it is not stored.
	logic [31:0] scan_period_q;
	logic [15:0] response_delay_q;
	logic [31:0] reset_delay_q;
	logic [7:0]  max_tries_q;
	logic        use_interrupt_q;

	// Poll state.
	prtm_pkg::phase_t                     phase_q, phase_d;
	logic [prtm_pkg::TIME_BITS-1:0]       start_stamp_q, start_stamp_d;
	logic [prtm_pkg::TRY_BITS-1:0]        try_count_q, try_count_d;
	logic                                 zero_pending_q, zero_pending_d;

	// Input stage.
	logic                                 valid_s1;
	logic [prtm_pkg::NOW_BITS-1:0]        now_s1;
	logic                                 enabled_s1;
	logic                                 zero_request_s1;
	logic                                 device_ready_s1;
	logic                                 irq_pending_s1;
	logic                                 response_ready_s1;

	// Output stage.
	logic                                 valid_s2;
	logic [prtm_pkg::OUT_BITS-1:0]        data_s2;

	logic                                 advance;
	logic [prtm_pkg::CMP_BITS-1:0]        now_wide;
	logic [prtm_pkg::TIME_BITS-1:0]       now_t;
	logic [prtm_pkg::TIME_BITS-1:0]       elapsed;
	logic [prtm_pkg::CMP_BITS-1:0]        elapsed_wide;
	logic [24:0]                          resp_limit;
	logic [8:0]                           try_next;
	logic                                 zero_latched;
	logic [prtm_pkg::SEND_BITS-1:0]       send_d;
	logic                                 take_d;
	logic                                 flush_d;
	logic                                 clr_d;

	// Handshakes: the input stage moves on whenever the output slot is free
	// or being emptied.
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = data_s2;

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q    <= 32'd1000;
			response_delay_q <= 16'd100;
			reset_delay_q    <= 32'd1000;
			max_tries_q      <= 8'd3;
			use_interrupt_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				prtm_pkg::REG_SCAN_PERIOD:    scan_period_q    <= cfg_data;
				prtm_pkg::REG_RESPONSE_DELAY: response_delay_q <= cfg_data[15:0];
				prtm_pkg::REG_RESET_DELAY:    reset_delay_q    <= cfg_data;
				prtm_pkg::REG_MAX_TRIES:      max_tries_q      <= cfg_data[7:0];
				prtm_pkg::REG_USE_INTERRUPT:  use_interrupt_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			now_s1            <= s_tdata[31:0];
			enabled_s1        <= s_tdata[32];
			zero_request_s1   <= s_tdata[33];
			device_ready_s1   <= s_tdata[34];
			irq_pending_s1    <= s_tdata[35];
			response_ready_s1 <= s_tdata[36];
		end
	end

	// Timestamp masked to the timer width and elapsed time since request start.
	assign now_wide     = prtm_pkg::CMP_BITS'(now_s1);
	assign now_t        = now_wide[prtm_pkg::TIME_BITS-1:0];
	assign elapsed      = now_t - start_stamp_q;
	assign elapsed_wide = prtm_pkg::CMP_BITS'(elapsed);
	assign try_next     = {1'b0, try_count_q} + 9'd1;
	assign resp_limit   = response_delay_q * try_next;
	assign zero_latched = zero_pending_q || zero_request_s1;

	// Next state and commands for one step.
	always_comb begin
		phase_d        = phase_q;
		start_stamp_d  = start_stamp_q;
		try_count_d    = try_count_q;
		zero_pending_d = zero_latched;
		send_d         = prtm_pkg::SEND_NONE;
		take_d         = 1'b0;
		flush_d        = 1'b0;
		clr_d          = 1'b0;
		case (phase_q)
			prtm_pkg::PH_WAIT_IRQ: begin
				if (enabled_s1) begin
					if (irq_pending_s1) begin
						take_d = response_ready_s1;
						clr_d  = 1'b1;
					end
				end else begin
					phase_d = prtm_pkg::PH_IDLE;
				end
			end
			prtm_pkg::PH_WAIT_SCAN: begin
				if (enabled_s1) begin
					if (elapsed_wide >= prtm_pkg::CMP_BITS'(scan_period_q)) begin
						start_stamp_d = now_t;
						try_count_d   = '0;
						send_d        = prtm_pkg::SEND_REQUEST;
						phase_d       = prtm_pkg::PH_WAIT_RESP;
					end else if (zero_latched) begin
						send_d  = prtm_pkg::SEND_ZERO;
						phase_d = prtm_pkg::PH_WAIT_RESET;
					end
				end else begin
					phase_d = prtm_pkg::PH_IDLE;
				end
			end
			prtm_pkg::PH_WAIT_RESP: begin
				if (elapsed_wide >= prtm_pkg::CMP_BITS'(resp_limit)) begin
					if (response_ready_s1) begin
						take_d  = 1'b1;
						phase_d = prtm_pkg::PH_WAIT_SCAN;
					end else if (max_tries_q == 8'd0 || try_next >= {1'b0, max_tries_q}) begin
						flush_d = 1'b1;
						phase_d = prtm_pkg::PH_WAIT_SCAN;
					end else begin
						send_d      = prtm_pkg::SEND_REQUEST;
						try_count_d = try_next[7:0];
					end
				end
			end
			prtm_pkg::PH_WAIT_RESET: begin
				if (elapsed_wide >= prtm_pkg::CMP_BITS'(reset_delay_q)) begin
					zero_pending_d = 1'b0;
					phase_d        = prtm_pkg::PH_WAIT_SCAN;
				end
			end
			default: begin
				if (device_ready_s1 && enabled_s1) begin
					if (use_interrupt_q) begin
						phase_d = prtm_pkg::PH_WAIT_IRQ;
					end else begin
						start_stamp_d = now_t;
						try_count_d   = '0;
						send_d        = prtm_pkg::SEND_REQUEST;
						phase_d       = prtm_pkg::PH_WAIT_RESP;
					end
				end
			end
		endcase
	end

	// State update, one step per advancing request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= prtm_pkg::PH_IDLE;
			start_stamp_q  <= '0;
			try_count_q    <= '0;
			zero_pending_q <= 1'b0;
		end else if (advance) begin
			phase_q        <= phase_d;
			start_stamp_q  <= start_stamp_d;
			try_count_q    <= try_count_d;
			zero_pending_q <= zero_pending_d;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {try_count_d, prtm_pkg::phase_code(phase_d),
				clr_d, flush_d, take_d, send_d};
		end
	end

endmodule
